@@ rtl/aalu_pkg.sv @@
// Shared types and codes for the accumulator ALU with flags.
package aalu_pkg;

    // Operation codes carried in the request.
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_DAA  = 5'd10,
        OP_CPL  = 5'd11,
        OP_SCF  = 5'd12,
        OP_CCF  = 5'd13,
        OP_RLC  = 5'd14,
        OP_RRC  = 5'd15,
        OP_RL   = 5'd16,
        OP_RR   = 5'd17,
        OP_SLA  = 5'd18,
        OP_SRA  = 5'd19,
        OP_SWAP = 5'd20,
        OP_SRL  = 5'd21,
        OP_BIT  = 5'd22,
        OP_RES  = 5'd23,
        OP_SET  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28,
        OP_LDA  = 5'd29,
        OP_LDF  = 5'd30
    } t_op;

    // Rotate and shift kinds of the shifter.
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift;

    // Flag register, zero flag in the top bit.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // Constants of the decimal adjust.
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

endpackage

@@ rtl/accumulator_alu_with_flags.sv @@
// Top level: request register, ALU, architectural state and result register.
//
// An 8-bit CPU style ALU holding the accumulator and the Z, N, H, C flags.
// Requests arrive on the s_axis channel: each names an operation, an operand
// byte and a bit index. Every request yields exactly one result on m_axis,
// carrying the result byte, the new flags and the new accumulator.
//
// A taken request sits in the request register, passes the combinational
// ALU and is captured in the result register together with the new state.
// One request per cycle is sustained while the receiver takes results; the
// accumulator and flag loop closes through the ALU and the state registers,
// so a request may use the state left by the one just before it.
//
// Synchronous active-low reset clears the accumulator, the flags and both
// valid bits. When the receiver stalls, the result holds in the result
// register and one more request can wait in the request register; after
// that s_axis_tready drops until the result is taken.
module accumulator_alu_with_flags
    import aalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[4:0], operand[12:5], bit_index[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[7:0], flags_out[11:8], acc_out[19:12], zero fill[23:20]
    output logic [23:0] m_axis_tdata
);

    logic       r_in_valid;
    logic [4:0] r_req_type;
    logic [7:0] r_operand;
    logic [2:0] r_bit_index;
    logic       r_out_valid;
    logic [7:0] r_result;
    logic [7:0] r_acc;
    t_flags     r_flags;

    logic       advance;
    logic [7:0] alu_result;
    logic [7:0] alu_acc;
    t_flags     alu_flags;

    // A request moves to the result register when that register is free or drained.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_req_type  <= s_axis_tdata[4:0];
            r_operand   <= s_axis_tdata[12:5];
            r_bit_index <= s_axis_tdata[15:13];
        end
    end

    // Datapath.
    aalu_alu u_alu (
        .i_op        (t_op'(r_req_type)),
        .i_operand   (r_operand),
        .i_bit_index (r_bit_index),
        .i_acc       (r_acc),
        .i_flags     (r_flags),
        .o_result    (alu_result),
        .o_acc       (alu_acc),
        .o_flags     (alu_flags)
    );

    // Architectural state and result register update together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= 8'd0;
            r_flags     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_acc       <= alu_acc;
                r_flags     <= alu_flags;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_result <= alu_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_acc, r_flags, r_result};

    // A waiting request is never dropped before it reaches the ALU.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("request lost while waiting");

    // Every request that passes the ALU shows up as a valid result.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result missing after ALU pass");

    // Loading the flags takes the operand's upper nibble.
    a_ldf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_req_type == OP_LDF)) |=> (r_flags == t_flags'($past(r_operand[7:4]))))
        else $error("flag load mismatch");

    // Reset clears the state and both valid bits.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_acc == 8'd0) && (r_flags == '0) && !r_in_valid && !r_out_valid)
        else $error("state not cleared by reset");

endmodule

@@ rtl/aalu_shift.sv @@
// Rotate, shift and nibble swap unit for one byte.
module aalu_shift
    import aalu_pkg::*;
(
    input  t_shift     i_kind,
    input  logic [7:0] i_value,
    input  logic       i_cin,
    output logic [7:0] o_value,
    output logic       o_cout
);

    // Select the shifted byte and the bit that leaves it.
    always_comb begin
        unique case (i_kind)
            SH_RLC: begin
                o_value = {i_value[6:0], i_value[7]};
                o_cout  = i_value[7];
            end
            SH_RRC: begin
                o_value = {i_value[0], i_value[7:1]};
                o_cout  = i_value[0];
            end
            SH_RL: begin
                o_value = {i_value[6:0], i_cin};
                o_cout  = i_value[7];
            end
            SH_RR: begin
                o_value = {i_cin, i_value[7:1]};
                o_cout  = i_value[0];
            end
            SH_SLA: begin
                o_value = {i_value[6:0], 1'b0};
                o_cout  = i_value[7];
            end
            SH_SRA: begin
                o_value = {i_value[7], i_value[7:1]};
                o_cout  = i_value[0];
            end
            SH_SWAP: begin
                o_value = {i_value[3:0], i_value[7:4]};
                o_cout  = 1'b0;
            end
            default: begin
                o_value = {1'b0, i_value[7:1]};
                o_cout  = i_value[0];
            end
        endcase
    end

endmodule

@@ rtl/aalu_alu.sv @@
// Combinational datapath: computes result, accumulator and flags for one request.
module aalu_alu
    import aalu_pkg::*;
(
    input  t_op        i_op,
    input  logic [7:0] i_operand,
    input  logic [2:0] i_bit_index,
    input  logic [7:0] i_acc,
    input  t_flags     i_flags,
    output logic [7:0] o_result,
    output logic [7:0] o_acc,
    output t_flags     o_flags
);

    logic       carry_in;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] bit_mask;
    logic [7:0] daa_adj;
    logic       daa_carry;
    logic [7:0] daa_val;
    logic [7:0] op_shift_val;
    logic       op_shift_cout;
    logic [7:0] acc_shift_val;
    logic       acc_shift_cout;

    // Carry is used only by the with-carry forms.
    assign carry_in = ((i_op == OP_ADC) || (i_op == OP_SBC)) ? i_flags.c : 1'b0;

    // Nine-bit add and subtract, five-bit nibble paths for half carry.
    assign add_sum  = {1'b0, i_acc} + {1'b0, i_operand} + {8'd0, carry_in};
    assign add_half = {1'b0, i_acc[3:0]} + {1'b0, i_operand[3:0]} + {4'd0, carry_in};
    assign sub_diff = {1'b0, i_acc} - {1'b0, i_operand} - {8'd0, carry_in};
    assign sub_half = {1'b0, i_acc[3:0]} - {1'b0, i_operand[3:0]} - {4'd0, carry_in};

    assign inc_val  = i_operand + 8'd1;
    assign dec_val  = i_operand - 8'd1;
    assign bit_mask = 8'd1 << i_bit_index;

    // Decimal adjust in both directions.
    always_comb begin
        daa_adj   = 8'd0;
        daa_carry = i_flags.c;
        if (i_flags.n) begin
            if (i_flags.h) daa_adj = daa_adj + DAA_LO_ADJ;
            if (i_flags.c) daa_adj = daa_adj + DAA_HI_ADJ;
            daa_val = i_acc - daa_adj;
        end else begin
            if (i_flags.h || (i_acc[3:0] > DAA_LO_LIM)) daa_adj = daa_adj + DAA_LO_ADJ;
            if (i_flags.c || (i_acc > DAA_HI_LIM)) begin
                daa_adj   = daa_adj + DAA_HI_ADJ;
                daa_carry = 1'b1;
            end
            daa_val = i_acc + daa_adj;
        end
    end

    // Shifter on the operand for the prefixed rotates and shifts.
    aalu_shift u_op_shift (
        .i_kind  (t_shift'(3'(i_op - OP_RLC))),
        .i_value (i_operand),
        .i_cin   (i_flags.c),
        .o_value (op_shift_val),
        .o_cout  (op_shift_cout)
    );

    // Shifter on the accumulator for the short rotates.
    aalu_shift u_acc_shift (
        .i_kind  (t_shift'(3'(i_op - OP_RLCA))),
        .i_value (i_acc),
        .i_cin   (i_flags.c),
        .o_value (acc_shift_val),
        .o_cout  (acc_shift_cout)
    );

    // Result selection by operation.
    always_comb begin
        o_result = i_acc;
        o_acc    = i_acc;
        o_flags  = i_flags;
        unique case (i_op)
            OP_ADD, OP_ADC: begin
                o_result = add_sum[7:0];
                o_acc    = add_sum[7:0];
                o_flags  = '{z: (add_sum[7:0] == 8'd0), n: 1'b0,
                             h: add_half[4], c: add_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                o_result = sub_diff[7:0];
                if (i_op != OP_CP) o_acc = sub_diff[7:0];
                o_flags  = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1,
                             h: sub_half[4], c: sub_diff[8]};
            end
            OP_AND: begin
                o_result = i_acc & i_operand;
                o_acc    = i_acc & i_operand;
                o_flags  = '{z: ((i_acc & i_operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR: begin
                o_result = i_acc ^ i_operand;
                o_acc    = i_acc ^ i_operand;
                o_flags  = '{z: ((i_acc ^ i_operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR: begin
                o_result = i_acc | i_operand;
                o_acc    = i_acc | i_operand;
                o_flags  = '{z: ((i_acc | i_operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC: begin
                o_result = inc_val;
                o_flags  = '{z: (inc_val == 8'd0), n: 1'b0,
                             h: (inc_val[3:0] == 4'h0), c: i_flags.c};
            end
            OP_DEC: begin
                o_result = dec_val;
                o_flags  = '{z: (dec_val == 8'd0), n: 1'b1,
                             h: (dec_val[3:0] == 4'hF), c: i_flags.c};
            end
            OP_DAA: begin
                o_result = daa_val;
                o_acc    = daa_val;
                o_flags  = '{z: (daa_val == 8'd0), n: i_flags.n, h: 1'b0, c: daa_carry};
            end
            OP_CPL: begin
                o_result = ~i_acc;
                o_acc    = ~i_acc;
                o_flags  = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            OP_SCF: begin
                o_flags  = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            OP_CCF: begin
                o_flags  = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: ~i_flags.c};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                o_result = op_shift_val;
                o_flags  = '{z: (op_shift_val == 8'd0), n: 1'b0, h: 1'b0, c: op_shift_cout};
            end
            OP_BIT: begin
                o_result = i_operand;
                o_flags  = '{z: ((i_operand & bit_mask) == 8'd0), n: 1'b0,
                             h: 1'b1, c: i_flags.c};
            end
            OP_RES: begin
                o_result = i_operand & ~bit_mask;
            end
            OP_SET: begin
                o_result = i_operand | bit_mask;
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
                o_result = acc_shift_val;
                o_acc    = acc_shift_val;
                o_flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_shift_cout};
            end
            OP_LDA: begin
                o_result = i_operand;
                o_acc    = i_operand;
            end
            OP_LDF: begin
                o_result = {i_operand[7:4], 4'h0};
                o_flags  = t_flags'(i_operand[7:4]);
            end
            default: begin
                // Unused code leaves everything as it is.
                o_result = i_acc;
            end
        endcase
    end

endmodule
